>>> hdl/cot_pkg.sv
// ============================================================================
// cot_pkg: shared types and constants for the clock offset tracker
// Widths, register reset values, command and register index codes, and the
// record that carries one transaction from the front stage to the core.
// ============================================================================
package cot_pkg;

    localparam int WORD_W              = 64;
    localparam int ALPHA_W             = 17;
    localparam int THR_W               = 30;
    localparam int CFG_W               = 30;
    localparam int CFG_IDX_W           = 1;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd62259;
    localparam logic [THR_W-1:0]   THR_RESET   = 30'd10000000;

    typedef enum logic {
        CMD_SYNC    = 1'b0,
        CMD_CONVERT = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA     = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_idx_t;

    // One transaction after the measurement stage
    typedef struct packed {
        cmd_t                     command;
        logic                     take;        // sync reply with positive remote stamp
        logic signed [WORD_W-1:0] now_time;
        logic signed [WORD_W-1:0] remote_time;
        logic signed [WORD_W-1:0] meas;        // saturated measured offset
    } stage_t;

endpackage

>>> hdl/cot_front.sv
// ============================================================================
// cot_front: input register and offset measurement stage
// Captures the accepted transaction, computes (sent + now - 2*remote)/2
// truncated toward zero and saturated to 64 bits, and registers the result.
// ============================================================================
module cot_front (
    input  logic                             clk,
    input  logic                             in_load,
    input  logic                             stage_load,
    input  logic                             command,
    input  logic signed [cot_pkg::WORD_W-1:0] now_time,
    input  logic signed [cot_pkg::WORD_W-1:0] sent_stamp,
    input  logic signed [cot_pkg::WORD_W-1:0] remote_stamp,
    input  logic signed [cot_pkg::WORD_W-1:0] remote_time,
    output cot_pkg::stage_t                  stage
);

    localparam int W = cot_pkg::WORD_W;

    cot_pkg::cmd_t         cmd_reg;
    logic signed [W-1:0]   now_reg;
    logic signed [W-1:0]   sent_reg;
    logic signed [W-1:0]   rstamp_reg;
    logic signed [W-1:0]   rtime_reg;
    cot_pkg::stage_t       stage_reg;
    cot_pkg::stage_t       stage_next;

    logic signed [W+1:0]   sum;
    logic signed [W+1:0]   rounded;
    logic signed [W+1:0]   half;
    logic signed [W-1:0]   meas;

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            cmd_reg    <= cot_pkg::cmd_t'(command);
            now_reg    <= now_time;
            sent_reg   <= sent_stamp;
            rstamp_reg <= remote_stamp;
            rtime_reg  <= remote_time;
        end
    end

    always_comb
    begin
        sum = {{2{sent_reg[W-1]}}, sent_reg} + {{2{now_reg[W-1]}}, now_reg}
            - {rstamp_reg[W-1], rstamp_reg, 1'b0};
        // add one before the shift when negative: rounds toward zero
        rounded = sum + {{(W+1){1'b0}}, sum[W+1]};
        half    = rounded >>> 1;
        if (half[W+1:W-1] == 3'b000 || half[W+1:W-1] == 3'b111)
            meas = half[W-1:0];
        else if (half[W+1])
            meas = {1'b1, {(W-1){1'b0}}};
        else
            meas = {1'b0, {(W-1){1'b1}}};

        stage_next.command     = cmd_reg;
        stage_next.take        = !rstamp_reg[W-1] && (rstamp_reg != '0);
        stage_next.now_time    = now_reg;
        stage_next.remote_time = rtime_reg;
        stage_next.meas        = meas;
    end

    always_ff @(posedge clk)
    begin
        if (stage_load)
            stage_reg <= stage_next;
    end

    assign stage = stage_reg;

endmodule

>>> hdl/cot_core.sv
// ============================================================================
// cot_core: offset state, jump/smoothing update, conversion, result register
// Holds the stored offset and sync flag and produces one result per
// transaction.
// ============================================================================
module cot_core #(
    parameter int ALPHA_FRAC_BITS = cot_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  cot_pkg::stage_t                   stage,
    input  logic [cot_pkg::ALPHA_W-1:0]       alpha,
    input  logic [cot_pkg::THR_W-1:0]         threshold,
    output logic signed [cot_pkg::WORD_W-1:0] local_time,
    output logic signed [cot_pkg::WORD_W-1:0] offset_value,
    output logic                              synced,
    output logic                              used_fallback,
    output logic                              state_synced
);

    localparam int W    = cot_pkg::WORD_W;
    localparam int AW   = cot_pkg::ALPHA_W;
    localparam int CW   = (ALPHA_FRAC_BITS + 1 > AW) ? ALPHA_FRAC_BITS + 1 : AW;
    localparam int DW   = cot_pkg::THR_W + 2;     // step width, holds +-threshold
    localparam int PW   = DW + AW + 1;
    localparam logic [CW-1:0] ONE = CW'(1) << ALPHA_FRAC_BITS;

    logic signed [W-1:0]  offset_reg;
    logic signed [W-1:0]  offset_next;
    logic                 synced_reg;
    logic                 synced_next;

    logic signed [W-1:0]  local_reg;
    logic signed [W-1:0]  local_next;
    logic signed [W-1:0]  offout_reg;
    logic                 syncout_reg;
    logic                 fb_reg;
    logic                 fb_next;

    logic signed [W:0]    diff;
    logic signed [W:0]    thr_s;
    logic                 jump;
    logic [AW-1:0]        a_eff;
    logic signed [DW-1:0] step;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] scaled;
    logic signed [W-1:0]  smooth;
    logic signed [W:0]    sum;

    always_comb
    begin
        diff  = {offset_reg[W-1], offset_reg} - {stage.meas[W-1], stage.meas};
        thr_s = $signed({{(W+1-cot_pkg::THR_W){1'b0}}, threshold});
        jump  = (diff > thr_s) || (diff < -thr_s);

        a_eff = (CW'(alpha) > ONE) ? AW'(ONE) : alpha;

        // only used when |meas - old| <= threshold, so the low bits suffice
        step   = stage.meas[DW-1:0] - offset_reg[DW-1:0];
        prod   = {{(AW+1){step[DW-1]}}, step} * $signed({{(DW+1){1'b0}}, a_eff});
        scaled = prod >>> ALPHA_FRAC_BITS;
        smooth = offset_reg + {{(W-PW){scaled[PW-1]}}, scaled};

        sum = {stage.remote_time[W-1], stage.remote_time} + {offset_reg[W-1], offset_reg};

        offset_next = offset_reg;
        synced_next = synced_reg;
        local_next  = '0;
        fb_next     = 1'b0;

        case (stage.command)
            cot_pkg::CMD_SYNC:
            begin
                if (stage.take)
                begin
                    if (!synced_reg || jump)
                    begin
                        offset_next = stage.meas;
                        synced_next = 1'b1;
                    end
                    else
                    begin
                        offset_next = smooth;
                    end
                end
            end
            cot_pkg::CMD_CONVERT:
            begin
                if (!synced_reg || sum[W])
                begin
                    local_next = stage.now_time;
                    fb_next    = 1'b1;
                end
                else if (sum[W-1])
                begin
                    local_next = {1'b0, {(W-1){1'b1}}};
                end
                else
                begin
                    local_next = sum[W-1:0];
                end
            end
            default:
            begin
                offset_next = offset_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            synced_reg <= 1'b0;
        end
        else if (load)
        begin
            offset_reg <= offset_next;
            synced_reg <= synced_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            local_reg   <= local_next;
            offout_reg  <= offset_next;
            syncout_reg <= synced_next;
            fb_reg      <= fb_next;
        end
    end

    assign local_time    = local_reg;
    assign offset_value  = offout_reg;
    assign synced        = syncout_reg;
    assign used_fallback = fb_reg;
    assign state_synced  = synced_reg;

endmodule

>>> hdl/clock_offset_tracker_top.sv
// ============================================================================
// clock_offset_tracker_top: remote-to-local clock offset tracker
// Measures clock offset from two-way sync replies, smooths or jumps the
// stored offset, and converts remote times to local time.
// ============================================================================
// Pipeline: a transaction accepted at the input passes through the input
//   register, measurement register and result register, in that order.
// Throughput: one transaction per cycle while out_stall is low; the offset
//   update and conversion are combinational before the result register.
// Reset: rst_n clears all valid bits, the stored offset and the sync flag,
//   and loads the alpha and threshold registers with their defaults.
module clock_offset_tracker_top #(
    parameter int ALPHA_FRAC_BITS = cot_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_we,
    input  logic [cot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cot_pkg::CFG_W-1:0]         cfg_data,

    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic signed [cot_pkg::WORD_W-1:0] now_time,
    input  logic signed [cot_pkg::WORD_W-1:0] sent_stamp,
    input  logic signed [cot_pkg::WORD_W-1:0] remote_stamp,
    input  logic signed [cot_pkg::WORD_W-1:0] remote_time,

    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cot_pkg::WORD_W-1:0] local_time,
    output logic signed [cot_pkg::WORD_W-1:0] offset_value,
    output logic                              synced,
    output logic                              used_fallback
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [cot_pkg::ALPHA_W-1:0] alpha_reg;
    logic [cot_pkg::THR_W-1:0]   thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= cot_pkg::ALPHA_RESET;
            thr_reg   <= cot_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cot_pkg::cfg_idx_t'(cfg_index))
                cot_pkg::CFG_ALPHA:     alpha_reg <= cfg_data[cot_pkg::ALPHA_W-1:0];
                cot_pkg::CFG_THRESHOLD: thr_reg   <= cfg_data[cot_pkg::THR_W-1:0];
                default:                thr_reg   <= thr_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline flow control. Each stage takes a new transaction when it is
    // empty or its content moves on in the same cycle, so all three stages
    // stay full under a stalled output and a bubble never blocks the input.
    // ---------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, s2_free, s1_free;
    logic in_load, s2_load, out_load;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        out_load = s2_valid_reg && out_free;
        s2_free  = !s2_valid_reg || out_free;
        s2_load  = s1_valid_reg && s2_free;
        s1_free  = !s1_valid_reg || s2_free;
        in_load  = in_valid && s1_free;

        out_valid_next = out_load || (out_valid_reg && out_stall);
        s2_valid_next  = s2_load || (s2_valid_reg && !out_free);
        s1_valid_next  = in_load || (s1_valid_reg && !s2_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = !s1_free;
    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------------
    // Datapath: measurement stage, then offset state and result register
    // ---------------------------------------------------------------------
    cot_pkg::stage_t stage;
    logic            state_synced;

    cot_front u_front (
        .clk          (clk),
        .in_load      (in_load),
        .stage_load   (s2_load),
        .command      (command),
        .now_time     (now_time),
        .sent_stamp   (sent_stamp),
        .remote_stamp (remote_stamp),
        .remote_time  (remote_time),
        .stage        (stage)
    );

    cot_core #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .stage         (stage),
        .alpha         (alpha_reg),
        .threshold     (thr_reg),
        .local_time    (local_time),
        .offset_value  (offset_value),
        .synced        (synced),
        .used_fallback (used_fallback),
        .state_synced  (state_synced)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // input only stalls when every stage holds a transaction and the
    // result is being held off
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // once synced, the tracker never drops back to unsynced
    a_sync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(state_synced))
        else $error("sync flag cleared after being set");

    // before the first accepted sync reply the offset stays zero
    a_unsynced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !synced) |-> (offset_value == '0))
        else $error("offset nonzero while unsynced");

    // unsynced results are either sync transactions (local time zero) or
    // fallback conversions
    a_unsynced_fb: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !synced) |-> (used_fallback || (local_time == '0)))
        else $error("unsynced conversion without fallback");

endmodule
